@@ hw/rtl/kf2_pkg.sv @@
// ----------------------------------------------------------------------------
// kf2_pkg: shared types and constants for the two-state Kalman filter
// Holds the fixed-point format, command codes, controller states and the
// command/status structs that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package kf2_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 64;

  typedef enum logic [1:0] {
    CMD_PREDICT = 2'd0,
    CMD_CORRECT = 2'd1,
    CMD_RELOAD  = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_F_ROW0  = 3'd0,
    REG_F_ROW1  = 3'd1,
    REG_H_ROW   = 3'd2,
    REG_R_NOISE = 3'd3,
    REG_X_INIT  = 3'd4,
    REG_P_ROW0  = 3'd5,
    REG_P_ROW1  = 3'd6
  } reg_idx_t;

  // Datapath register file slots
  typedef enum logic [4:0] {
    S_X0, S_X1, S_P00, S_P01, S_P10, S_P11,
    S_T0, S_T1, S_K0, S_K1, S_Y, S_S,
    S_A00, S_A01, S_A10, S_A11, S_U0, S_U1, S_Z, S_ZERO
  } slot_t;

  // Operand sources for the shared multiply-accumulate
  typedef enum logic [4:0] {
    O_X0, O_X1, O_P00, O_P01, O_P10, O_P11,
    O_T0, O_T1, O_K0, O_K1, O_Y,
    O_A00, O_A01, O_A10, O_A11,
    O_F00, O_F01, O_F10, O_F11, O_H0, O_H1, O_ZERO
  } opnd_t;

  typedef enum logic [2:0] {
    ACC_ZERO, ACC_U0, ACC_U1, ACC_Z, ACC_R, ACC_ONE, ACC_X0, ACC_X1
  } init_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RUN, ST_DIV, ST_DONE, ST_OUT
  } state_t;

  typedef struct packed {
    logic   start_acc;   // load accumulator with init
    init_t  init_sel;
    logic   mac;         // add signed product
    logic   sub;         // subtract product instead
    opnd_t  opa;
    opnd_t  opb;
    logic   wr;          // saturate accumulator into a slot
    slot_t  dst;
    logic   commit;      // copy T to X and K0/K1/Y/S to P
    logic   div_start;
    logic   div_sel;     // 0: t0, 1: t1
    logic   load_cmd;
    logic   reload;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic s_zero;
  } dp_sts_t;

endpackage

@@ hw/rtl/kalman_filter_two_state.sv @@
// ----------------------------------------------------------------------------
// kalman_filter_two_state: two-state linear Kalman filter, scalar measurement
// Signed Q16.16 predict / correct / reload with saturation.
// ----------------------------------------------------------------------------
// One item at a time. All products run through one shared 32x32
// multiply-accumulate that takes one product per cycle, and a correct
// also uses a serial 48-bit divider for the gain. The input accepts the
// next item as soon as the result has been moved into the output register.
module kalman_filter_two_state (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // motion_0, motion_1, measurement (32 each)
  input  logic [1:0]   in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // state_0, state_1, cov_00, cov_01, cov_10, cov_11
  output logic [1:0]   out_tuser,  // innov_zero, saturated
  input  logic         cfg_we,
  input  logic [kf2_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [kf2_pkg::CFG_DW-1:0]    cfg_wdata
);
  import kf2_pkg::*;

  logic [CFG_DW-1:0] f_row0_r, f_row1_r, h_row_r, x_init_r, p0_r, p1_r;
  logic [30:0]       r_noise_r;
  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic              busy, done, zf;
  logic signed [DW-1:0] x_o [2];
  logic signed [DW-1:0] p_o [4];
  logic              clip_o;
  logic              ov_r;
  logic [191:0]      od_r;
  logic [1:0]        ou_r;
  logic              in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_row0_r  <= '0;
      f_row1_r  <= '0;
      h_row_r   <= '0;
      r_noise_r <= '0;
      x_init_r  <= '0;
      p0_r      <= '0;
      p1_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_F_ROW0:  f_row0_r  <= cfg_wdata;
        REG_F_ROW1:  f_row1_r  <= cfg_wdata;
        REG_H_ROW:   h_row_r   <= cfg_wdata;
        REG_R_NOISE: r_noise_r <= cfg_wdata[30:0];
        REG_X_INIT:  x_init_r  <= cfg_wdata;
        REG_P_ROW0:  p0_r      <= cfg_wdata;
        REG_P_ROW1:  p1_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;

  kf2_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_cmd    (in_tuser),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .zero_flag (zf),
    .out_free  (!ov_r || out_tready)
  );

  kf2_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .f_row0      (f_row0_r),
    .f_row1      (f_row1_r),
    .h_row       (h_row_r),
    .r_noise     (r_noise_r),
    .x_init      (x_init_r),
    .p_init_row0 (p0_r),
    .p_init_row1 (p1_r),
    .motion_0    (in_tdata[31:0]),
    .motion_1    (in_tdata[63:32]),
    .measurement (in_tdata[95:64]),
    .x_out       (x_o),
    .p_out       (p_o),
    .clip_out    (clip_o)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (done) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
    if (done) begin
      od_r <= {p_o[3], p_o[2], p_o[1], p_o[0], x_o[1], x_o[0]};
      ou_r <= {clip_o, zf};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

endmodule

@@ hw/rtl/kf2_div.sv @@
// ----------------------------------------------------------------------------
// kf2_div: serial signed divider
// Computes sat32((t << FRAC_BITS) / s) truncated toward zero, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module kf2_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [kf2_pkg::DW-1:0] num,
  input  logic signed [kf2_pkg::DW-1:0] den,
  output logic                          busy,
  output logic signed [kf2_pkg::DW-1:0] quo,
  output logic                          clip
);
  import kf2_pkg::*;

  localparam int NW = DW + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] n_r, n_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt;
  logic          busy_r, busy_nxt;
  logic [DW:0]   trial;
  logic [NW:0]   sq;

  always_comb begin
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    trial    = {rem_r[DW-1:0], n_r[NW-1]} - {1'b0, d_r};
    if (start) begin
      n_nxt    = {(num[DW-1] ? DW'(-num) : DW'(num)), {FRAC_BITS{1'b0}}};
      d_nxt    = den[DW-1] ? DW'(-den) : DW'(den);
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = CW'(NW);
      neg_nxt  = num[DW-1] ^ den[DW-1];
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt = {n_r[NW-2:0], 1'b0};
      if (!trial[DW]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DW-1:0], n_r[NW-1]};
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    sq = neg_r ? -{1'b0, q_r} : {1'b0, q_r};
    if (!neg_r && q_r > NW'({1'b0, {(DW-1){1'b1}}})) begin
      quo  = {1'b0, {(DW-1){1'b1}}};
      clip = 1'b1;
    end else if (neg_r && q_r > NW'({1'b1, {(DW-1){1'b0}}})) begin
      quo  = {1'b1, {(DW-1){1'b0}}};
      clip = 1'b1;
    end else begin
      quo  = sq[DW-1:0];
      clip = 1'b0;
    end
  end

  assign busy = busy_r;

endmodule

@@ hw/rtl/kf2_datapath.sv @@
// ----------------------------------------------------------------------------
// kf2_datapath: register file, shared multiply-accumulate and divider
// One signed 32x32 product per cycle, floor-shifted and accumulated into a
// wide accumulator that is saturated on write-back.
// ----------------------------------------------------------------------------
module kf2_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kf2_pkg::dp_cmd_t              cmd,
  output kf2_pkg::dp_sts_t              sts,
  input  logic [kf2_pkg::CFG_DW-1:0]    f_row0,
  input  logic [kf2_pkg::CFG_DW-1:0]    f_row1,
  input  logic [kf2_pkg::CFG_DW-1:0]    h_row,
  input  logic [30:0]                   r_noise,
  input  logic [kf2_pkg::CFG_DW-1:0]    x_init,
  input  logic [kf2_pkg::CFG_DW-1:0]    p_init_row0,
  input  logic [kf2_pkg::CFG_DW-1:0]    p_init_row1,
  input  logic signed [kf2_pkg::DW-1:0] motion_0,
  input  logic signed [kf2_pkg::DW-1:0] motion_1,
  input  logic signed [kf2_pkg::DW-1:0] measurement,
  output logic signed [kf2_pkg::DW-1:0] x_out [2],
  output logic signed [kf2_pkg::DW-1:0] p_out [4],
  output logic                          clip_out
);
  import kf2_pkg::*;

  localparam int AW = 2 * DW + 4;

  logic signed [DW-1:0] rf_r [20];
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [DW-1:0] a_r, b_r;
  logic                 mv_r, sb_r;
  logic signed [2*DW-1:0] prod;
  logic signed [AW-1:0] pshift;
  logic signed [DW-1:0] sat_v;
  logic                 sat_c;
  logic                 clip_r;
  logic                 div_sel_r;
  logic                 div_was_r;
  logic signed [DW-1:0] dquo;
  logic                 dclip;
  logic                 dbusy;
  logic signed [DW-1:0] init_v;
  logic signed [DW-1:0] fv [4];
  logic signed [DW-1:0] hv [2];

  assign fv[0] = f_row0[31:0];
  assign fv[1] = f_row0[63:32];
  assign fv[2] = f_row1[31:0];
  assign fv[3] = f_row1[63:32];
  assign hv[0] = h_row[31:0];
  assign hv[1] = h_row[63:32];

  function automatic logic signed [DW-1:0] pick(opnd_t o, logic signed [DW-1:0] rf [20],
                                                logic signed [DW-1:0] f [4],
                                                logic signed [DW-1:0] h [2]);
    logic signed [DW-1:0] v;
    case (o)
      O_X0:    v = rf[S_X0];
      O_X1:    v = rf[S_X1];
      O_P00:   v = rf[S_P00];
      O_P01:   v = rf[S_P01];
      O_P10:   v = rf[S_P10];
      O_P11:   v = rf[S_P11];
      O_T0:    v = rf[S_T0];
      O_T1:    v = rf[S_T1];
      O_K0:    v = rf[S_K0];
      O_K1:    v = rf[S_K1];
      O_Y:     v = rf[S_Y];
      O_A00:   v = rf[S_A00];
      O_A01:   v = rf[S_A01];
      O_A10:   v = rf[S_A10];
      O_A11:   v = rf[S_A11];
      O_F00:   v = f[0];
      O_F01:   v = f[1];
      O_F10:   v = f[2];
      O_F11:   v = f[3];
      O_H0:    v = h[0];
      O_H1:    v = h[1];
      default: v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    case (cmd.init_sel)
      ACC_U0:  init_v = rf_r[S_U0];
      ACC_U1:  init_v = rf_r[S_U1];
      ACC_Z:   init_v = rf_r[S_Z];
      ACC_R:   init_v = DW'({1'b0, r_noise});
      ACC_ONE: init_v = DW'(1 << FRAC_BITS);
      ACC_X0:  init_v = rf_r[S_X0];
      ACC_X1:  init_v = rf_r[S_X1];
      default: init_v = '0;
    endcase
  end

  assign prod   = a_r * b_r;
  assign pshift = AW'(prod >>> FRAC_BITS);

  always_comb begin
    acc_nxt = acc_r;
    if (mv_r) acc_nxt = sb_r ? acc_r - pshift : acc_r + pshift;
    if (cmd.start_acc) acc_nxt = AW'(init_v);
  end

  always_comb begin
    if (acc_r > AW'(32'sh7fffffff)) begin
      sat_v = 32'sh7fffffff;
      sat_c = 1'b1;
    end else if (acc_r < -AW'(64'sh80000000)) begin
      sat_v = 32'sh80000000;
      sat_c = 1'b1;
    end else begin
      sat_v = acc_r[DW-1:0];
      sat_c = 1'b0;
    end
  end

  kf2_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (cmd.div_sel ? rf_r[S_T1] : rf_r[S_T0]),
    .den   (rf_r[S_S]),
    .busy  (dbusy),
    .quo   (dquo),
    .clip  (dclip)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 20; i++) rf_r[i] <= '0;
      mv_r      <= 1'b0;
      clip_r    <= 1'b0;
      div_was_r <= 1'b0;
    end else begin
      mv_r      <= cmd.mac;
      div_was_r <= dbusy;
      if (cmd.load_cmd) begin
        rf_r[S_U0] <= motion_0;
        rf_r[S_U1] <= motion_1;
        rf_r[S_Z]  <= measurement;
        clip_r     <= 1'b0;
      end
      if (cmd.wr) begin
        rf_r[cmd.dst] <= sat_v;
        clip_r        <= clip_r | sat_c;
      end
      if (div_was_r && !dbusy) begin
        rf_r[div_sel_r ? S_K1 : S_K0] <= dquo;
        clip_r <= clip_r | dclip;
      end
      if (cmd.commit) begin
        rf_r[S_P00] <= rf_r[S_K0];
        rf_r[S_P01] <= rf_r[S_K1];
        rf_r[S_P10] <= rf_r[S_Y];
        rf_r[S_P11] <= rf_r[S_S];
        rf_r[S_X0]  <= rf_r[S_T0];
        rf_r[S_X1]  <= rf_r[S_T1];
      end
      if (cmd.reload) begin
        rf_r[S_X0]  <= x_init[31:0];
        rf_r[S_X1]  <= x_init[63:32];
        rf_r[S_P00] <= p_init_row0[31:0];
        rf_r[S_P01] <= p_init_row0[63:32];
        rf_r[S_P10] <= p_init_row1[31:0];
        rf_r[S_P11] <= p_init_row1[63:32];
      end
    end
    if (cmd.div_start) div_sel_r <= cmd.div_sel;
    a_r   <= pick(cmd.opa, rf_r, fv, hv);
    b_r   <= pick(cmd.opb, rf_r, fv, hv);
    sb_r  <= cmd.sub;
    acc_r <= acc_nxt;
  end

  assign sts.div_busy = dbusy | (div_was_r & ~dbusy);
  assign sts.s_zero   = (rf_r[S_S] == '0);

  assign x_out[0] = rf_r[S_X0];
  assign x_out[1] = rf_r[S_X1];
  assign p_out[0] = rf_r[S_P00];
  assign p_out[1] = rf_r[S_P01];
  assign p_out[2] = rf_r[S_P10];
  assign p_out[3] = rf_r[S_P11];
  assign clip_out = clip_r;

endmodule

@@ hw/rtl/kf2_ctrl.sv @@
// ----------------------------------------------------------------------------
// kf2_ctrl: sequencer for predict, correct and reload
// Steps through a micro-program of multiply-accumulate operations; the
// operands of each term are registered before the product is accumulated,
// and a sum is written back after its last term has been accumulated.
// ----------------------------------------------------------------------------
module kf2_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic [1:0]       in_cmd,
  input  kf2_pkg::dp_sts_t sts,
  output kf2_pkg::dp_cmd_t cmd,
  output logic             busy,
  output logic             done,
  output logic             zero_flag,
  input  logic             out_free
);
  import kf2_pkg::*;

  // Micro-op: init, up to two terms (opa, opb, sub), destination.
  typedef struct packed {
    init_t init;
    opnd_t a0;
    opnd_t b0;
    logic  s0;
    opnd_t a1;
    opnd_t b1;
    logic  s1;
    slot_t dst;
  } uop_t;

  localparam int NP = 10;  // predict ops
  localparam int NC1 = 5;  // correct before divide (last op is NC1 - 2)
  localparam int NC2 = 10; // correct after divide

  function automatic uop_t prog(logic [1:0] ph, logic [3:0] i);
    uop_t u;
    u = '{ACC_ZERO, O_ZERO, O_ZERO, 1'b0, O_ZERO, O_ZERO, 1'b0, S_ZERO};
    if (ph == 2'd0) begin
      case (i)
        4'd0: u = '{ACC_U0,  O_F00, O_X0,  1'b0, O_F01, O_X1,  1'b0, S_T0};
        4'd1: u = '{ACC_U1,  O_F10, O_X0,  1'b0, O_F11, O_X1,  1'b0, S_T1};
        4'd2: u = '{ACC_ZERO, O_F00, O_P00, 1'b0, O_F01, O_P10, 1'b0, S_A00};
        4'd3: u = '{ACC_ZERO, O_F00, O_P01, 1'b0, O_F01, O_P11, 1'b0, S_A01};
        4'd4: u = '{ACC_ZERO, O_F10, O_P00, 1'b0, O_F11, O_P10, 1'b0, S_A10};
        4'd5: u = '{ACC_ZERO, O_F10, O_P01, 1'b0, O_F11, O_P11, 1'b0, S_A11};
        4'd6: u = '{ACC_ZERO, O_A00, O_F00, 1'b0, O_A01, O_F01, 1'b0, S_K0};
        4'd7: u = '{ACC_ZERO, O_A00, O_F10, 1'b0, O_A01, O_F11, 1'b0, S_K1};
        4'd8: u = '{ACC_ZERO, O_A10, O_F00, 1'b0, O_A11, O_F01, 1'b0, S_Y};
        default: u = '{ACC_ZERO, O_A10, O_F10, 1'b0, O_A11, O_F11, 1'b0, S_S};
      endcase
    end else if (ph == 2'd1) begin
      case (i)
        4'd0: u = '{ACC_Z,   O_H0,  O_X0,  1'b1, O_H1,  O_X1,  1'b1, S_Y};
        4'd1: u = '{ACC_ZERO, O_P00, O_H0, 1'b0, O_P01, O_H1,  1'b0, S_T0};
        4'd2: u = '{ACC_ZERO, O_P10, O_H0, 1'b0, O_P11, O_H1,  1'b0, S_T1};
        4'd3: u = '{ACC_R,   O_H0,  O_T0,  1'b0, O_H1,  O_T1,  1'b0, S_S};
        default: u = '{ACC_ZERO, O_ZERO, O_ZERO, 1'b0, O_ZERO, O_ZERO, 1'b0, S_ZERO};
      endcase
    end else begin
      case (i)
        4'd0: u = '{ACC_ONE,  O_K0, O_H0, 1'b1, O_ZERO, O_ZERO, 1'b0, S_A00};
        4'd1: u = '{ACC_ZERO, O_K0, O_H1, 1'b1, O_ZERO, O_ZERO, 1'b0, S_A01};
        4'd2: u = '{ACC_ZERO, O_K1, O_H0, 1'b1, O_ZERO, O_ZERO, 1'b0, S_A10};
        4'd3: u = '{ACC_ONE,  O_K1, O_H1, 1'b1, O_ZERO, O_ZERO, 1'b0, S_A11};
        4'd4: u = '{ACC_X0,   O_K0, O_Y,  1'b0, O_ZERO, O_ZERO, 1'b0, S_T0};
        4'd5: u = '{ACC_X1,   O_K1, O_Y,  1'b0, O_ZERO, O_ZERO, 1'b0, S_T1};
        4'd6: u = '{ACC_ZERO, O_A00, O_P00, 1'b0, O_A01, O_P10, 1'b0, S_K0};
        4'd7: u = '{ACC_ZERO, O_A00, O_P01, 1'b0, O_A01, O_P11, 1'b0, S_K1};
        4'd8: u = '{ACC_ZERO, O_A10, O_P00, 1'b0, O_A11, O_P10, 1'b0, S_Y};
        default: u = '{ACC_ZERO, O_A10, O_P01, 1'b0, O_A11, O_P11, 1'b0, S_S};
      endcase
    end
    return u;
  endfunction

  state_t     st_r, st_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [3:0] op_r, op_nxt;
  logic [2:0] cy_r, cy_nxt;
  logic       dsel_r, dsel_nxt;
  logic       zf_r, zf_nxt;
  uop_t       u;

  assign u = prog(ph_r, op_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      ph_r   <= '0;
      op_r   <= '0;
      cy_r   <= '0;
      dsel_r <= 1'b0;
      zf_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ph_r   <= ph_nxt;
      op_r   <= op_nxt;
      cy_r   <= cy_nxt;
      dsel_r <= dsel_nxt;
      zf_r   <= zf_nxt;
    end
  end

  // cy_r 0: start acc + issue term0; 1: issue term1; 2,3: drain; 4: write
  always_comb begin
    st_nxt   = st_r;
    ph_nxt   = ph_r;
    op_nxt   = op_r;
    cy_nxt   = cy_r;
    dsel_nxt = dsel_r;
    zf_nxt   = zf_r;
    cmd      = '0;
    cmd.init_sel = ACC_ZERO;
    cmd.opa  = O_ZERO;
    cmd.opb  = O_ZERO;
    cmd.dst  = S_ZERO;
    done     = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load_cmd = 1'b1;
          zf_nxt   = 1'b0;
          op_nxt   = '0;
          cy_nxt   = '0;
          case (in_cmd)
            CMD_PREDICT: begin ph_nxt = 2'd0; st_nxt = ST_RUN; end
            CMD_CORRECT: begin ph_nxt = 2'd1; st_nxt = ST_RUN; end
            CMD_RELOAD:  begin cmd.reload = 1'b1; st_nxt = ST_OUT; end
            default:     st_nxt = ST_OUT;
          endcase
        end
      end
      ST_RUN: begin
        case (cy_r)
          3'd0: begin
            cmd.start_acc = 1'b1; cmd.init_sel = u.init;
            cmd.opa = u.a0; cmd.opb = u.b0; cmd.sub = u.s0; cmd.mac = 1'b1;
          end
          3'd1: begin
            cmd.opa = u.a1; cmd.opb = u.b1; cmd.sub = u.s1; cmd.mac = 1'b1;
          end
          3'd4: begin
            cmd.wr = 1'b1; cmd.dst = u.dst;
          end
          default: ;
        endcase
        cy_nxt = cy_r + 3'd1;
        if (cy_r == 3'd4) begin
          cy_nxt = '0;
          op_nxt = op_r + 4'd1;
          if (ph_r == 2'd0 && op_r == 4'(NP - 1)) begin
            st_nxt = ST_DONE;
          end else if (ph_r == 2'd1 && op_r == 4'(NC1 - 2)) begin
            st_nxt   = ST_DIV;
            dsel_nxt = 1'b0;
            cy_nxt   = '0;
          end else if (ph_r == 2'd2 && op_r == 4'(NC2 - 1)) begin
            st_nxt = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        if (cy_r == 3'd0) begin
          if (sts.s_zero) begin
            zf_nxt = 1'b1;
            st_nxt = ST_OUT;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = dsel_r;
            cy_nxt        = 3'd1;
          end
        end else if (!sts.div_busy) begin
          if (dsel_r) begin
            ph_nxt = 2'd2;
            op_nxt = '0;
            cy_nxt = '0;
            st_nxt = ST_RUN;
          end else begin
            dsel_nxt      = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_sel   = 1'b1;
          end
        end
      end
      ST_DONE: begin
        cmd.commit = 1'b1;
        st_nxt     = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          done   = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign busy      = (st_r != ST_IDLE);
  assign zero_flag = zf_r;

endmodule
